// ===== rtl/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Queue size and derived widths
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned TOTAL_W  = 5;

  // Operation codes carried on the input tuser
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  // Result status codes carried on the output tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the incoming beat
    logic exec;  // apply the operation and register the result
  } ctrl_cmd_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue.
`timescale 1ns / 1ps

module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Handshakes and datapath commands
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_RESP);
  assign cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec   = (state_q == S_EXEC);

endmodule

// ===== rtl/spq_datapath.sv =====
// Sorted slot file with per-slot compare-and-shift and the result register.
`timescale 1ns / 1ps

module spq_datapath
  import spq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  input  logic [1:0]          op_i,
  input  logic [WORD_W-1:0]   data_i,
  input  logic [WORD_W-1:0]   prio_i,
  output logic [WORD_W-1:0]   res_data_o,
  output logic [1:0]          res_status_o,
  output logic                res_empty_o,
  output logic [TOTAL_W-1:0]  res_total_o
);

  // Captured beat
  logic [1:0]        op_q;
  logic [WORD_W-1:0] dat_q;
  logic [WORD_W-1:0] pri_q;

  // Slots, slot 0 is the head; only slots below the count are meaningful
  logic [WORD_W-1:0] slot_dat_q [CAPACITY];
  logic [WORD_W-1:0] slot_pri_q [CAPACITY];
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // Result register
  logic [WORD_W-1:0]  res_data_q, res_data_d;
  status_e            res_status_q, res_status_d;
  logic               res_empty_q;
  logic [TOTAL_W-1:0] res_total_q;

  logic                is_full;
  logic                is_empty;
  logic [CAPACITY-1:0] ins;
  logic                do_enq;
  logic                do_deq;
  logic [CNT_W+TOTAL_W-1:0] cnt_wide;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      dat_q <= data_i;
      pri_q <= prio_i;
    end
  end

  assign is_full  = (cnt_q == CNT_W'(CAPACITY));
  assign is_empty = (cnt_q == '0);

  // Slot takes part in the insert: stored with priority <= new, or the first free slot
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ins[i] = ((CNT_W'(i) < cnt_q) && ($signed(slot_pri_q[i]) <= $signed(pri_q)))
               || (CNT_W'(i) == cnt_q);
    end
  end

  // Operation decode, count and result
  always_comb begin
    do_enq       = 1'b0;
    do_deq       = 1'b0;
    cnt_d        = cnt_q;
    res_data_d   = '0;
    res_status_d = ST_OK;
    case (op_e'(op_q))
      OP_ENQ: begin
        if (is_full) begin
          res_status_d = ST_FULL;
        end else begin
          do_enq = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (is_empty) begin
          res_status_d = ST_EMPTY;
        end else begin
          do_deq     = 1'b1;
          res_data_d = slot_dat_q[0];
          cnt_d      = cnt_q - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (is_empty) begin
          res_status_d = ST_EMPTY;
        end else begin
          res_data_d = slot_dat_q[0];
        end
      end
      default: begin
        res_status_d = ST_OK;
      end
    endcase
  end

  // Per-slot compare-and-shift
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (cmd_i.exec && do_enq && ins[g]) begin
        if (g == 0) begin
          slot_dat_q[g] <= dat_q;
          slot_pri_q[g] <= pri_q;
        end else if (!ins[(g == 0) ? 0 : g-1]) begin
          slot_dat_q[g] <= dat_q;
          slot_pri_q[g] <= pri_q;
        end else begin
          slot_dat_q[g] <= slot_dat_q[(g == 0) ? 0 : g-1];
          slot_pri_q[g] <= slot_pri_q[(g == 0) ? 0 : g-1];
        end
      end else if (cmd_i.exec && do_deq && (g < CAPACITY-1)) begin
        slot_dat_q[g] <= slot_dat_q[(g < CAPACITY-1) ? g+1 : g];
        slot_pri_q[g] <= slot_pri_q[(g < CAPACITY-1) ? g+1 : g];
      end
    end
  end

  // Count and status
  assign cnt_wide = {{TOTAL_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_data_q   <= res_data_d;
      res_status_q <= res_status_d;
      res_empty_q  <= (cnt_d == '0);
      res_total_q  <= cnt_wide[TOTAL_W-1:0];
    end
  end

  assign res_data_o   = res_data_q;
  assign res_status_o = res_status_q;
  assign res_empty_o  = res_empty_q;
  assign res_total_o  = res_total_q;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: top level with stream ports and checks.
//
// Input channel (s_axis): one beat is one operation. tuser carries the
// operation (enqueue, dequeue, peek); tdata carries the data and priority
// used by an enqueue. Output channel (m_axis): exactly one beat per input
// beat, carrying the head data (dequeue/peek), the status in tuser, the
// empty flag and the entry count after the operation.
// Entries are kept sorted, highest priority at the head; among equal
// priorities the newest is served first. An enqueue into a full queue is
// dropped with status full; dequeue or peek on an empty queue gives status
// empty. Unused operation codes leave the queue unchanged with status ok.
// The result beat is registered: an accepted beat is captured, then the
// compare-and-shift over all slots applies it and the output register takes
// the result. One operation is in flight at a time: no new beat is accepted
// until the receiver has taken the result beat.
// Reset empties the queue (the count clears, slot contents are don't-care).
// When the receiver stalls, the result beat holds and s_axis_tready stays low.
`timescale 1ns / 1ps

module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] item_data, [63:32] item_priority
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] result_data, [32] queue_empty,
                                     // [37:33] entry_total, [39:38] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  ctrl_cmd_t          cmd;
  logic [WORD_W-1:0]  res_data;
  logic [1:0]         res_status;
  logic               res_empty;
  logic [TOTAL_W-1:0] res_total;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  spq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (s_axis_tuser),
    .data_i      (s_axis_tdata[31:0]),
    .prio_i      (s_axis_tdata[63:32]),
    .res_data_o  (res_data),
    .res_status_o(res_status),
    .res_empty_o (res_empty),
    .res_total_o (res_total)
  );

  assign m_axis_tdata = {2'b00, res_total, res_empty, res_data};
  assign m_axis_tuser = res_status;

  // One operation in flight: never accepting while a result is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // An accepted beat blocks further input on the next cycle
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted during operation");

  // Full status only with a full queue
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |->
      (m_axis_tdata[37:33] == CAPACITY[TOTAL_W-1:0]) && !m_axis_tdata[32])
    else $error("full status with a queue that is not full");

  // Empty status leaves an empty queue and no data
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_EMPTY)) |->
      m_axis_tdata[32] && (m_axis_tdata[31:0] == '0))
    else $error("empty status with data or entries");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the sorted priority queue.
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  // Spare operation code: the queue must ignore it and still reply
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int HOLD_LEN = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_SHOWN = 10;

  // One operation beat and one reply beat, unpacked
  typedef struct {
    logic [1:0]  op;
    logic [31:0] data;
    logic [31:0] prio;
  } queue_op_t;

  typedef struct {
    logic [31:0] data;
    status_e     status;
    logic        empty;
    logic [4:0]  total;
  } queue_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  // Shadow copy of the sorted slots, head at index 0
  logic signed [31:0] shadow_data[CAPACITY];
  logic signed [31:0] shadow_prio[CAPACITY];
  int                 shadow_count = 0;

  queue_op_t    op_backlog[$];
  queue_reply_t expected_replies[$];
  queue_op_t    next_op;

  int ops_queued = 0;
  int ops_taken = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_armed = 1'b0;
  int hold_cycles = 0;
  logic holding;

  always #10 clk_i = ~clk_i;

  sorted_priority_queue u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  // Apply one operation to the shadow queue and return the reply it must give
  function automatic queue_reply_t apply_queue_op(queue_op_t q);
    queue_reply_t r;
    int pos;
    int i;
    r.data = '0;
    r.status = ST_OK;
    case (q.op)
      OP_ENQ: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // first slot whose priority is equal or lower; ties go ahead
          pos = shadow_count;
          for (i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_prio[i] <= $signed(q.prio)) pos = i;
          end
          for (i = shadow_count; i > pos; i--) begin
            shadow_data[i] = shadow_data[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_data[pos] = q.data;
          shadow_prio[pos] = q.prio;
          shadow_count++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = shadow_data[0];
          if (q.op == OP_DEQ) begin
            for (i = 0; i + 1 < shadow_count; i++) begin
              shadow_data[i] = shadow_data[i+1];
              shadow_prio[i] = shadow_prio[i+1];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    r.empty = (shadow_count == 0);
    r.total = shadow_count[4:0];
    return r;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%s", msg);
  endfunction

  task automatic push_op(logic [1:0] op, logic [31:0] data, logic [31:0] prio);
    queue_op_t q;
    q.op = op;
    q.data = data;
    q.prio = prio;
    op_backlog.push_back(q);
    ops_queued++;
  endtask

  // Random priority: half the time a narrow band so ties are common
  function automatic logic [31:0] pick_prio();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 32'($signed($urandom_range(0, 6)) - 3);
    if (sel == 9) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'hffff_ffff;
        default: return 32'h0;
      endcase
    end
    return $urandom;
  endfunction

  // Random operations in runs whose enqueue share swings between draining and filling
  task automatic queue_random(int n);
    int enq_pct;
    int k;
    int r;
    logic [1:0] op;
    enq_pct = 50;
    for (k = 0; k < n; k++) begin
      if (k % 32 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 15;
          1: enq_pct = 85;
          default: enq_pct = 50;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_NOP;
      else if (r < 3 + enq_pct) op = OP_ENQ;
      else if ($urandom_range(0, 3) == 0) op = OP_PEEK;
      else op = OP_DEQ;
      push_op(op, $urandom, pick_prio());
    end
  endtask

  // Wait until every queued operation is taken and answered
  task automatic wait_drain();
    while (ops_taken != ops_queued || expected_replies.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sender: offer backlog beats, record the expected reply on acceptance
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        next_op.op = s_tuser;
        next_op.data = s_tdata[31:0];
        next_op.prio = s_tdata[63:32];
        expected_replies.push_back(apply_queue_op(next_op));
        ops_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (op_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_op = op_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {next_op.prio, next_op.data};
          s_tuser  <= next_op.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  assign holding = hold_armed && (hold_cycles < HOLD_LEN);

  always @(posedge clk_i) begin
    if (holding) hold_cycles <= hold_cycles + 1;
  end

  // Receiver: check each reply beat against the oldest expectation
  always @(posedge clk_i or negedge rst_n) begin
    queue_reply_t want;
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_replies.size() == 0) begin
          note_failure($sformatf("unexpected reply data=%h status=%0d tdata=%h",
                                 m_tdata[31:0], m_tuser, m_tdata));
        end else begin
          want = expected_replies.pop_front();
          if (m_tdata[31:0] !== want.data || m_tuser !== want.status ||
              m_tdata[32] !== want.empty || m_tdata[37:33] !== want.total) begin
            note_failure($sformatf(
              "reply mismatch: exp data=%h status=%0d empty=%0b total=%0d, got data=%h status=%0d empty=%0b total=%0d",
              want.data, want.status, want.empty, want.total,
              m_tdata[31:0], m_tuser, m_tdata[32], m_tdata[37:33]));
          end
        end
      end
      m_tready <= !holding && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // Directed: empty queue, extremes, ties, full queue, spare opcode
    push_op(OP_DEQ, $urandom, $urandom);
    push_op(OP_PEEK, $urandom, $urandom);
    push_op(OP_NOP, $urandom, $urandom);
    push_op(OP_ENQ, 32'h7fff_ffff, 32'h7fff_ffff);
    push_op(OP_ENQ, 32'h8000_0000, 32'h8000_0000);
    push_op(OP_ENQ, 32'h0000_0000, 32'h0000_0000);
    push_op(OP_ENQ, 32'hffff_ffff, 32'hffff_ffff);
    push_op(OP_ENQ, 32'h0000_0001, 32'h0000_0000);
    push_op(OP_ENQ, 32'h0000_0002, 32'h0000_0000);
    for (k = 0; k < 10; k++) push_op(OP_ENQ, $urandom, 32'(k - 5));
    push_op(OP_ENQ, 32'h1234_5678, 32'h7fff_ffff);
    push_op(OP_PEEK, $urandom, $urandom);
    push_op(OP_NOP, $urandom, $urandom);
    push_op(OP_DEQ, $urandom, $urandom);
    push_op(OP_DEQ, $urandom, $urandom);
    push_op(OP_DEQ, $urandom, $urandom);
    wait_drain();

    // Random phases with different idling on each side
    queue_random(400);
    wait_drain();

    sender_idle_pct = 78;
    queue_random(400);
    wait_drain();

    sender_idle_pct = 0;
    recv_stall_pct = 78;
    queue_random(400);
    wait_drain();

    sender_idle_pct = 12;
    recv_stall_pct = 12;
    queue_random(400);
    wait_drain();

    // Receiver holds off while the sender keeps offering
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_armed = 1'b1;
    queue_random(60);
    wait_drain();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
